// File: rtl/rs485_slave_poll_master_defines.svh
// Assertion macros used by the poll master RTL
`ifndef RS485_SLAVE_POLL_MASTER_DEFINES_SVH
`define RS485_SLAVE_POLL_MASTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RSPM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rspm check failed");

// next-cycle implication, checked outside reset
`define RSPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rspm check failed");

`endif

// File: rtl/rspm_pkg.sv
package rspm_pkg;

    localparam int MAX_SLAVES = 16;
    localparam int ADDR_W     = $clog2(MAX_SLAVES + 1);
    localparam int SLOT_W     = (MAX_SLAVES > 1) ? $clog2(MAX_SLAVES) : 1;
    localparam int DLY_W      = 8;
    localparam int THR_W      = 4;
    localparam int MISS_W     = 5;
    localparam int CFG_W      = 8;
    localparam int IDX_W      = 3;

    localparam logic [MISS_W-1:0] MISS_MAX = '1;

    localparam logic [DLY_W-1:0]  RST_TURNAROUND = 8'd11;
    localparam logic [DLY_W-1:0]  RST_SEND       = 8'd15;
    localparam logic [DLY_W-1:0]  RST_LISTEN     = 8'd3;
    localparam logic [DLY_W-1:0]  RST_TIMEOUT    = 8'd50;
    localparam logic [THR_W-1:0]  RST_FAILS      = 4'd3;
    localparam logic [ADDR_W-1:0] RST_SLAVES     = ADDR_W'(MAX_SLAVES);

    typedef enum logic [IDX_W-1:0] {
        REG_TURNAROUND  = 3'd0,
        REG_SEND_DELAY  = 3'd1,
        REG_LISTEN      = 3'd2,
        REG_TIMEOUT     = 3'd3,
        REG_FAILS       = 3'd4,
        REG_SLAVE_COUNT = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic              talk;
        logic              send_now;
        logic [ADDR_W-1:0] poll_address;
        logic              reply_taken;
        logic              slave_lost;
        logic              rx_fault;
        logic [SLOT_W-1:0] slot;
    } t_step;

endpackage

// File: rtl/rspm_in_if.sv
interface rspm_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic rx_valid;
    logic rx_fault;
    logic tx_idle;

    modport source (output valid, output operation, output rx_valid, output rx_fault,
                    output tx_idle, input ready);
    modport sink (input valid, input operation, input rx_valid, input rx_fault,
                  input tx_idle, output ready);
endinterface

// File: rtl/rspm_out_if.sv
interface rspm_out_if
    import rspm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              talk;
    logic              send_now;
    logic [ADDR_W-1:0] poll_address;
    logic              reply_taken;
    logic              slave_lost;
    logic              fault_raised;

    modport source (output valid, output talk, output send_now, output poll_address,
                    output reply_taken, output slave_lost, output fault_raised,
                    input ready);
    modport sink (input valid, input talk, input send_now, input poll_address,
                  input reply_taken, input slave_lost, input fault_raised,
                  output ready);
endinterface

// File: rtl/rspm_ram.sv
module rspm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/rspm_miss_store.sv
module rspm_miss_store
    import rspm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [SLOT_W-1:0] i_rd_slot,
    input  logic              i_wr_en,
    input  logic [SLOT_W-1:0] i_wr_slot,
    input  logic [MISS_W-1:0] i_wr_data,
    output logic [MISS_W-1:0] o_count
);
    logic [MAX_SLAVES-1:0] r_valid;
    logic                  r_rd_valid;
    logic                  r_fwd;
    logic [MISS_W-1:0]     r_fwd_data;
    logic [MISS_W-1:0]     ram_q;

    rspm_ram #(.WIDTH(MISS_W), .DEPTH(MAX_SLAVES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr_en),
        .i_waddr (i_wr_slot),
        .i_wdata (i_wr_data),
        .i_re    (i_rd_en),
        .i_raddr (i_rd_slot),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_slot] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_slot];
                r_fwd      <= i_wr_en && (i_wr_slot == i_rd_slot);
            end
        end
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_count = r_fwd ? r_fwd_data : (r_rd_valid ? ram_q : '0);
endmodule

// File: rtl/rspm_ctrl.sv
module rspm_ctrl
    import rspm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_step_en,
    input  logic              i_operation,
    input  logic              i_rx_valid,
    input  logic              i_rx_fault,
    input  logic              i_tx_idle,
    output t_step             o_step,
    output logic [THR_W-1:0]  o_fails_to_fault
);
    logic [DLY_W-1:0]  r_turnaround, r_send_delay, r_listen, r_timeout;
    logic [THR_W-1:0]  r_fails;
    logic [ADDR_W-1:0] r_slave_count;

    logic [DLY_W-1:0]  r_time, n_time;
    logic              r_pending, n_pending;
    logic              r_talking, n_talking;
    logic [ADDR_W-1:0] r_current, n_current;

    logic [ADDR_W-1:0] active;
    logic [ADDR_W-1:0] next_slave;
    logic              send_now;
    logic              lost;

    always_comb begin
        active = r_slave_count;
        if (active == '0) begin
            active = ADDR_W'(1);
        end
        if (active > ADDR_W'(MAX_SLAVES)) begin
            active = ADDR_W'(MAX_SLAVES);
        end
        if (r_current >= active || r_current == '0) begin
            next_slave = ADDR_W'(1);
        end else begin
            next_slave = r_current + ADDR_W'(1);
        end
    end

    always_comb begin
        n_time    = r_time;
        n_pending = r_pending;
        n_talking = r_talking;
        n_current = r_current;
        send_now  = 1'b0;
        lost      = 1'b0;
        if (!i_operation) begin
            if (r_time != '1) begin
                n_time = r_time + DLY_W'(1);
            end
        end else begin
            if (r_pending && r_time > r_turnaround && !r_talking) begin
                n_talking = 1'b1;
            end
            if (r_pending && r_time > r_send_delay && n_talking) begin
                send_now  = 1'b1;
                n_pending = 1'b0;
                n_time    = '0;
            end
            if (i_rx_valid) begin
                n_current = next_slave;
                n_time    = '0;
                n_pending = 1'b1;
            end else if (!n_pending && n_time > r_timeout) begin
                lost      = 1'b1;
                n_current = next_slave;
                n_time    = '0;
                n_pending = 1'b1;
            end
            if (i_tx_idle && n_time > r_listen && !n_pending && n_talking) begin
                n_talking = 1'b0;
            end
        end
    end

    always_comb begin
        o_step.talk         = n_talking;
        o_step.send_now     = send_now;
        o_step.poll_address = r_current;
        o_step.reply_taken  = i_operation && i_rx_valid;
        o_step.slave_lost   = lost;
        o_step.rx_fault     = i_rx_fault;
        if (r_current == '0 || r_current > ADDR_W'(MAX_SLAVES)) begin
            o_step.slot = '0;
        end else begin
            o_step.slot = SLOT_W'(r_current - ADDR_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turnaround  <= RST_TURNAROUND;
            r_send_delay  <= RST_SEND;
            r_listen      <= RST_LISTEN;
            r_timeout     <= RST_TIMEOUT;
            r_fails       <= RST_FAILS;
            r_slave_count <= RST_SLAVES;
            r_time        <= '0;
            r_pending     <= 1'b1;
            r_talking     <= 1'b0;
            r_current     <= ADDR_W'(1);
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    REG_TURNAROUND:  r_turnaround  <= i_cfg_data[DLY_W-1:0];
                    REG_SEND_DELAY:  r_send_delay  <= i_cfg_data[DLY_W-1:0];
                    REG_LISTEN:      r_listen      <= i_cfg_data[DLY_W-1:0];
                    REG_TIMEOUT:     r_timeout     <= i_cfg_data[DLY_W-1:0];
                    REG_FAILS:       r_fails       <= i_cfg_data[THR_W-1:0];
                    REG_SLAVE_COUNT: r_slave_count <= i_cfg_data[ADDR_W-1:0];
                    default: ;
                endcase
            end
            if (i_step_en) begin
                r_time    <= n_time;
                r_pending <= n_pending;
                r_talking <= n_talking;
                r_current <= n_current;
            end
        end
    end

    assign o_fails_to_fault = r_fails;
endmodule

// File: rtl/rs485_slave_poll_master.sv
// channel | dir | payload                                              | handshake
// i_in    | in  | operation, rx_valid, rx_fault, tx_idle               | valid/ready
// o_out   | out | talk, send_now, poll_address, reply_taken,           | valid/ready
//         |     | slave_lost, fault_raised                             |
// One word per cycle while the output is not stalled; a taken word is registered in the step
// stage together with its miss-count RAM read, and then in the output register.
// Synchronous active-low reset; miss counts read as zero until first written.
// A stalled output holds the step stage, and the input then drops ready.
`include "rs485_slave_poll_master_defines.svh"
module rs485_slave_poll_master
    import rspm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    rspm_in_if.sink          i_in,
    rspm_out_if.source       o_out
);
    t_step             step;
    logic [THR_W-1:0]  fails;
    logic              accept;

    logic              r_s1_valid;
    t_step             r_s1;
    logic              s1_move;
    logic [MISS_W-1:0] count;
    logic [MISS_W-1:0] wr_data;
    logic              wr_en;
    logic              fault;

    logic              r_out_valid;
    t_step             r_out;
    logic              r_out_fault;

    assign s1_move    = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_move;
    assign accept     = i_in.valid && i_in.ready;

    rspm_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_step_en        (accept),
        .i_operation      (i_in.operation),
        .i_rx_valid       (i_in.rx_valid),
        .i_rx_fault       (i_in.rx_fault),
        .i_tx_idle        (i_in.tx_idle),
        .o_step           (step),
        .o_fails_to_fault (fails)
    );

    rspm_miss_store u_miss (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_slot (step.slot),
        .i_wr_en   (wr_en),
        .i_wr_slot (r_s1.slot),
        .i_wr_data (wr_data),
        .o_count   (count)
    );

    always_comb begin
        wr_data = '0;
        fault   = 1'b0;
        if (r_s1.reply_taken) begin
            if (r_s1.rx_fault) begin
                wr_data = MISS_W'({1'b0, fails}) + MISS_W'(1);
                fault   = 1'b1;
            end
        end else begin
            wr_data = (count != MISS_MAX) ? count + MISS_W'(1) : count;
            fault   = wr_data >= MISS_W'(fails);
        end
        fault = fault && (r_s1.reply_taken || r_s1.slave_lost);
    end

    assign wr_en = r_s1_valid && s1_move && (r_s1.reply_taken || r_s1.slave_lost);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= r_s1_valid;
            end
        end
        if (accept) begin
            r_s1 <= step;
        end
        if (s1_move && r_s1_valid) begin
            r_out       <= r_s1;
            r_out_fault <= fault;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.talk         = r_out.talk;
    assign o_out.send_now     = r_out.send_now;
    assign o_out.poll_address = r_out.poll_address;
    assign o_out.reply_taken  = r_out.reply_taken;
    assign o_out.slave_lost   = r_out.slave_lost;
    assign o_out.fault_raised = r_out_fault;

    `RSPM_ASSERT_NOW(a_taken_lost_excl, o_out.valid, !(o_out.reply_taken && o_out.slave_lost))
    `RSPM_ASSERT_NOW(a_fault_cause, o_out.valid && o_out.fault_raised,
        o_out.reply_taken || o_out.slave_lost)
    `RSPM_ASSERT_NOW(a_stall_source, !i_in.ready, r_s1_valid && o_out.valid && !o_out.ready)
    `RSPM_ASSERT_NEXT(a_accept_fills, accept, r_s1_valid)
endmodule

// File: bench/poll_checker.sv
`timescale 1ns / 100ps
module poll_checker
    import rspm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    rspm_in_if               i_in,
    rspm_out_if              i_out,
    output int               o_due_count,
    output int               o_fail_count
);

    typedef struct packed {
        logic              talk;
        logic              send_now;
        logic [ADDR_W-1:0] poll_address;
        logic              reply_taken;
        logic              slave_lost;
        logic              fault_raised;
    } poll_word_t;

    logic [DLY_W-1:0]  turn_dly;
    logic [DLY_W-1:0]  send_dly;
    logic [DLY_W-1:0]  listen_dly;
    logic [DLY_W-1:0]  reply_tmo;
    logic [THR_W-1:0]  fail_thr;
    logic [ADDR_W-1:0] slaves_cfg;

    logic [DLY_W-1:0]  ticks;
    logic              send_due;
    logic              talking;
    logic [ADDR_W-1:0] served;
    logic [MISS_W-1:0] misses [MAX_SLAVES];

    poll_word_t poll_words_due[$];
    int         mismatches = 0;

    task automatic predict_poll(input logic op, input logic rxv, input logic rxf,
                                input logic txi, output poll_word_t word);
        logic [ADDR_W-1:0] active;
        logic [ADDR_W-1:0] next_addr;
        logic [SLOT_W-1:0] slot;
        active = (slaves_cfg == '0) ? ADDR_W'(1) :
                 (slaves_cfg > ADDR_W'(MAX_SLAVES)) ? ADDR_W'(MAX_SLAVES) : slaves_cfg;
        next_addr = (served >= active || served == '0) ? ADDR_W'(1) : served + 1'b1;
        slot = (served >= 1 && served <= MAX_SLAVES) ? SLOT_W'(served - 1'b1) : '0;
        word = '0;
        word.poll_address = served;
        if (!op) begin
            if (ticks != '1)
                ticks = ticks + 1'b1;
        end else begin
            if (send_due && ticks > turn_dly && !talking)
                talking = 1'b1;
            if (send_due && ticks > send_dly && talking) begin
                word.send_now = 1'b1;
                send_due = 1'b0;
                ticks = '0;
            end
            if (rxv) begin
                if (rxf) begin
                    misses[slot] = MISS_W'(fail_thr) + 1'b1;
                    word.fault_raised = 1'b1;
                end else begin
                    misses[slot] = '0;
                end
                word.reply_taken = 1'b1;
                served = next_addr;
                ticks = '0;
                send_due = 1'b1;
            end else if (!send_due && ticks > reply_tmo) begin
                ticks = '0;
                send_due = 1'b1;
                word.slave_lost = 1'b1;
                if (misses[slot] != MISS_MAX)
                    misses[slot] = misses[slot] + 1'b1;
                if (misses[slot] >= MISS_W'(fail_thr))
                    word.fault_raised = 1'b1;
                served = next_addr;
            end
            if (txi && ticks > listen_dly && !send_due && talking)
                talking = 1'b0;
        end
        word.talk = talking;
    endtask

    always @(posedge i_clk) begin : watch
        poll_word_t want;
        poll_word_t got;
        if (!i_rst_n) begin
            turn_dly   = RST_TURNAROUND;
            send_dly   = RST_SEND;
            listen_dly = RST_LISTEN;
            reply_tmo  = RST_TIMEOUT;
            fail_thr   = RST_FAILS;
            slaves_cfg = RST_SLAVES;
            ticks      = '0;
            send_due   = 1'b1;
            talking    = 1'b0;
            served     = ADDR_W'(1);
            for (int i = 0; i < MAX_SLAVES; i++)
                misses[i] = '0;
            poll_words_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    REG_TURNAROUND:  turn_dly   = i_cfg_data[DLY_W-1:0];
                    REG_SEND_DELAY:  send_dly   = i_cfg_data[DLY_W-1:0];
                    REG_LISTEN:      listen_dly = i_cfg_data[DLY_W-1:0];
                    REG_TIMEOUT:     reply_tmo  = i_cfg_data[DLY_W-1:0];
                    REG_FAILS:       fail_thr   = i_cfg_data[THR_W-1:0];
                    REG_SLAVE_COUNT: slaves_cfg = i_cfg_data[ADDR_W-1:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got = {i_out.talk, i_out.send_now, i_out.poll_address,
                       i_out.reply_taken, i_out.slave_lost, i_out.fault_raised};
                if (poll_words_due.size() == 0) begin
                    $display("%0t: poll word with none outstanding, expected none, actual %p",
                             $time, got);
                    mismatches++;
                end else begin
                    want = poll_words_due.pop_front();
                    if (got !== want) begin
                        $display({"%0t: poll word mismatch, expected talk=%b send=%b addr=%0d ",
                                  "taken=%b lost=%b fault=%b, actual talk=%b send=%b addr=%0d ",
                                  "taken=%b lost=%b fault=%b"}, $time,
                                 want.talk, want.send_now, want.poll_address,
                                 want.reply_taken, want.slave_lost, want.fault_raised,
                                 got.talk, got.send_now, got.poll_address,
                                 got.reply_taken, got.slave_lost, got.fault_raised);
                        mismatches++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_poll(i_in.operation, i_in.rx_valid, i_in.rx_fault, i_in.tx_idle, want);
                poll_words_due.push_back(want);
            end
        end
        o_due_count  <= poll_words_due.size();
        o_fail_count <= mismatches;
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
module testbench;
    import rspm_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0] cfg_data;
    int               due_count;
    int               fail_count;
    bit               idle_en  = 1'b1;
    bit               hold_req = 1'b0;

    rspm_in_if  in_ch ();
    rspm_out_if out_ch ();

    rs485_slave_poll_master dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    poll_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_due_count  (due_count),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic put_word(input logic op, input logic rxv, input logic rxf,
                            input logic txi);
        while (idle_en && !hold_req && $urandom_range(99) < 7) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.rx_valid  <= rxv;
        in_ch.rx_fault  <= rxf;
        in_ch.tx_idle   <= txi;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic random_words(input int n, input int tick_pct, input int rx_pct);
        for (int k = 0; k < n; k++)
            put_word($urandom_range(99) >= tick_pct, $urandom_range(99) < rx_pct,
                     1'($urandom_range(1)), $urandom_range(99) < 70);
    endtask

    // hold until every outstanding word has come back and the pipe is empty
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(input logic [7:0] turn, input logic [7:0] snd,
                               input logic [7:0] lsn, input logic [7:0] tmo,
                               input logic [7:0] fails, input logic [7:0] count);
        logic [CFG_W-1:0] vals [8];
        logic [IDX_W-1:0] idxs [8];
        drain();
        vals = '{turn, snd, lsn, tmo, fails, count, CFG_W'($urandom), CFG_W'($urandom)};
        idxs = '{REG_TURNAROUND, REG_SEND_DELAY, REG_LISTEN, REG_TIMEOUT,
                 REG_FAILS, REG_SLAVE_COUNT, REG_SPARE_A, REG_SPARE_B};
        for (int k = 0; k < 8; k++) begin
            cfg_wr_en <= 1'b1;
            cfg_idx   <= idxs[k];
            cfg_data  <= vals[k];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : sink_side
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                for (int n = 0; n < 80; n++)
                    @(posedge clk);
                hold_req = 1'b0;
            end else begin
                out_ch.ready <= !(idle_en && $urandom_range(99) < 7);
            end
        end
    end

    initial begin : source_side
        // {operation, rx_valid, rx_fault, tx_idle}
        logic [3:0] opening [25] = '{
            4'b1100, 4'b0111, 4'b0000, 4'b1001, 4'b0000, 4'b1010, 4'b1001, 4'b0000,
            4'b0000, 4'b1001, 4'b0000, 4'b0000, 4'b0000, 4'b0000, 4'b1000, 4'b1111,
            4'b0000, 4'b0000, 4'b1000, 4'b0000, 4'b1000, 4'b0000, 4'b0110, 4'b1011,
            4'b1110
        };
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_idx         <= REG_TURNAROUND;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= 1'b0;
        in_ch.rx_valid  <= 1'b0;
        in_ch.rx_fault  <= 1'b0;
        in_ch.tx_idle   <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        random_words(100, 75, 10);

        load_config(8'd1, 8'd2, 8'd1, 8'd3, 8'h02, 8'h03);
        foreach (opening[k])
            put_word(opening[k][3], opening[k][2], opening[k][1], opening[k][0]);
        random_words(130, 55, 20);

        idle_en = 1'b0;
        load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'h00, 8'h00);
        random_words(150, 50, 15);
        idle_en = 1'b1;

        load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 8'h01);
        random_words(250, 50, 1);

        load_config(8'd255, 8'd255, 8'd255, 8'd255, 8'h0F, 8'h1F);
        random_words(300, 90, 0);

        load_config(8'd6, 8'd9, 8'd4, 8'd20, 8'h34, 8'hF4);
        hold_req = 1'b1;
        random_words(200, 70, 20);

        load_config(8'd2, 8'd1, 8'd3, 8'd5, 8'h01, 8'h02);
        random_words(200, 55, 20);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && due_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/rspm_pkg.sv
rtl/rspm_in_if.sv
rtl/rspm_out_if.sv
rtl/rspm_ram.sv
rtl/rspm_miss_store.sv
rtl/rspm_ctrl.sv
rtl/rs485_slave_poll_master.sv
bench/poll_checker.sv
bench/testbench.sv
